// ----- sv/crb_pkg.sv -----
// shared types, constants and command structs for the cubic root bisection block
package crb_pkg;

    // default parameter values
    localparam int unsigned DEF_MAX_STEPS = 40;
    localparam int unsigned DEF_FRAC_BITS = 24;

    // field and datapath widths
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned TOL_W      = 31;
    localparam int unsigned STEP_W     = 7;
    localparam int unsigned CHUNK_W    = 32;
    localparam int unsigned NUM_CHUNKS = 3;
    localparam int unsigned MAG_W      = CHUNK_W * NUM_CHUNKS;
    localparam int unsigned ACC_W      = 100;
    localparam int unsigned CHUNK_IDX_W = 2;

    // register reset values
    localparam logic signed [DATA_W-1:0] COEF_SQUARE_RST   = -32'sd129184563;
    localparam logic signed [DATA_W-1:0] COEF_LINEAR_RST   = 32'sd322122547;
    localparam logic signed [DATA_W-1:0] COEF_CONSTANT_RST = -32'sd256691405;
    localparam logic [TOL_W-1:0]         TOLERANCE_RST     = 31'd8;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_COEF_SQUARE   = 2'd0,
        CFG_COEF_LINEAR   = 2'd1,
        CFG_COEF_CONSTANT = 2'd2,
        CFG_TOLERANCE     = 2'd3
    } t_cfg_idx;

    // result status codes
    typedef enum logic [1:0] {
        STAT_CONVERGED  = 2'd0,
        STAT_NO_SIGN    = 2'd1,
        STAT_STEP_LIMIT = 2'd2
    } t_status;

    // request payload
    typedef struct packed {
        logic signed [DATA_W-1:0] lower_end;
        logic signed [DATA_W-1:0] upper_end;
    } t_cr_req;

    // result payload
    typedef struct packed {
        logic signed [DATA_W-1:0] root;
        t_status                  status;
        logic [STEP_W-1:0]        steps_taken;
    } t_cr_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic                   load;
        logic                   x_to_upper;
        logic                   x_to_mid;
        logic                   setup_lin;
        logic                   setup_const;
        logic                   mul_en;
        logic [CHUNK_IDX_W-1:0] chunk;
        logic                   save_sa;
        logic                   bisect;
        logic                   root_wr;
        logic                   root_zero;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic same_sign;
        logic span_le_tol;
    } t_dp_stat;

endpackage

// ----- sv/crb_dp.sv -----
// datapath: config registers, interval registers, horner evaluation on one shared multiplier
module crb_dp #(
    parameter int unsigned FRAC_BITS = crb_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  crb_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [crb_pkg::DATA_W-1:0]      i_cfg_data,
    input  crb_pkg::t_cr_req                i_req,
    input  crb_pkg::t_dp_cmd                i_cmd,
    output crb_pkg::t_dp_stat               o_stat,
    output logic signed [crb_pkg::DATA_W-1:0] o_root
);
    import crb_pkg::*;

    // configuration registers
    logic signed [DATA_W-1:0] r_coef_square;
    logic signed [DATA_W-1:0] r_coef_linear;
    logic signed [DATA_W-1:0] r_coef_constant;
    logic [TOL_W-1:0]         r_tolerance;

    // interval and evaluation point
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_root;
    logic                     r_sa_neg;
    logic                     r_sa_zero;

    // multiply and accumulate
    logic [MAG_W-1:0]         r_mag_a;
    logic [DATA_W-1:0]        r_mag_x;
    logic                     r_neg;
    logic [2*CHUNK_W-1:0]     r_prod;
    logic [CHUNK_IDX_W-1:0]   r_prod_sh;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [DATA_W:0]   t0;
    logic [DATA_W:0]          t0_mag;
    logic [DATA_W-1:0]        x_mag;
    logic [ACC_W-1:0]         acc_abs;
    logic signed [ACC_W-1:0]  lin_term;
    logic signed [ACC_W-1:0]  const_term;
    logic signed [DATA_W:0]   sum_ab;
    logic signed [DATA_W:0]   diff_ab;
    logic [DATA_W:0]          span_ab;
    logic [CHUNK_W-1:0]       mul_a;
    logic [ACC_W-1:0]         prod_sh;
    logic [ACC_W-1:0]         prod_term;
    logic                     acc_neg;
    logic                     acc_zero;

    // first horner term and magnitudes
    assign t0        = {r_x[DATA_W-1], r_x} + {r_coef_square[DATA_W-1], r_coef_square};
    assign t0_mag    = t0[DATA_W] ? (DATA_W+1)'(-t0) : t0;
    assign x_mag     = r_x[DATA_W-1] ? DATA_W'(-r_x) : r_x;
    assign acc_abs   = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
    assign lin_term  = {{(ACC_W-DATA_W){r_coef_linear[DATA_W-1]}}, r_coef_linear}
                       <<< FRAC_BITS;
    assign const_term = {{(ACC_W-DATA_W){r_coef_constant[DATA_W-1]}}, r_coef_constant}
                       <<< (2 * FRAC_BITS);

    // midpoint rounds toward minus infinity, span is the absolute width
    assign sum_ab  = {r_a[DATA_W-1], r_a} + {r_b[DATA_W-1], r_b};
    assign diff_ab = {r_a[DATA_W-1], r_a} - {r_b[DATA_W-1], r_b};
    assign span_ab = diff_ab[DATA_W] ? (DATA_W+1)'(-diff_ab) : diff_ab;

    // sign of the evaluated polynomial
    assign acc_neg  = r_acc[ACC_W-1];
    assign acc_zero = (r_acc == '0);

    assign o_stat.same_sign   = !r_sa_zero && !acc_zero && (r_sa_neg == acc_neg);
    assign o_stat.span_le_tol = (span_ab <= {2'b00, r_tolerance});
    assign o_root             = r_root;

    // multiplier operand chunk
    always_comb begin
        unique case (i_cmd.chunk)
            2'd0:    mul_a = r_mag_a[CHUNK_W-1:0];
            2'd1:    mul_a = r_mag_a[2*CHUNK_W-1:CHUNK_W];
            2'd2:    mul_a = r_mag_a[3*CHUNK_W-1:2*CHUNK_W];
            default: mul_a = '0;
        endcase
    end

    // align partial product, fold in the sign with a carry-in
    always_comb begin
        unique case (r_prod_sh)
            2'd0:    prod_sh = ACC_W'(r_prod);
            2'd1:    prod_sh = ACC_W'(r_prod) << CHUNK_W;
            2'd2:    prod_sh = ACC_W'(r_prod) << (2 * CHUNK_W);
            default: prod_sh = '0;
        endcase
        prod_term = prod_sh ^ {ACC_W{r_neg}};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_square   <= COEF_SQUARE_RST;
            r_coef_linear   <= COEF_LINEAR_RST;
            r_coef_constant <= COEF_CONSTANT_RST;
            r_tolerance     <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COEF_SQUARE:   r_coef_square   <= i_cfg_data;
                CFG_COEF_LINEAR:   r_coef_linear   <= i_cfg_data;
                CFG_COEF_CONSTANT: r_coef_constant <= i_cfg_data;
                CFG_TOLERANCE:     r_tolerance     <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // interval registers and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_req.lower_end;
            r_b <= i_req.upper_end;
            r_x <= i_req.lower_end;
        end else if (i_cmd.x_to_upper) begin
            r_x <= r_b;
        end else if (i_cmd.x_to_mid) begin
            r_x <= sum_ab[DATA_W:1];
        end else if (i_cmd.bisect) begin
            if (o_stat.same_sign) begin
                r_a <= r_x;
            end else begin
                r_b <= r_x;
            end
        end
        if (i_cmd.save_sa) begin
            r_sa_neg  <= acc_neg;
            r_sa_zero <= acc_zero;
        end
        if (i_cmd.root_wr) begin
            r_root <= i_cmd.root_zero ? '0 : r_x;
        end
    end

    // product valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    // horner setup, partial products and accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod    <= mul_a * r_mag_x;
            r_prod_sh <= i_cmd.chunk;
        end
        if (i_cmd.setup_lin) begin
            r_mag_a <= MAG_W'(t0_mag);
            r_mag_x <= x_mag;
            r_neg   <= t0[DATA_W] ^ r_x[DATA_W-1];
            r_acc   <= lin_term;
        end else if (i_cmd.setup_const) begin
            r_mag_a <= acc_abs[MAG_W-1:0];
            r_neg   <= acc_neg ^ r_x[DATA_W-1];
            r_acc   <= const_term;
        end else if (r_prod_vld) begin
            r_acc   <= r_acc + $signed(prod_term) + $signed(ACC_W'(r_neg));
        end
    end

endmodule

// ----- sv/crb_ctrl.sv -----
// controller: sequences evaluations, bisection steps and the result strobe
module crb_ctrl #(
    parameter int unsigned MAX_STEPS = crb_pkg::DEF_MAX_STEPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  crb_pkg::t_dp_stat             i_stat,
    output crb_pkg::t_dp_cmd              o_cmd,
    output logic                          o_busy,
    output logic                          o_done,
    output crb_pkg::t_status              o_status,
    output logic [crb_pkg::STEP_W-1:0]    o_steps
);
    import crb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DRAIN,
        ST_SIGN,
        ST_CHECK
    } t_state;

    typedef enum logic [1:0] {
        PH_LOWER,
        PH_UPPER,
        PH_MID
    } t_phase;

    localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(NUM_CHUNKS - 1);
    localparam logic [STEP_W-1:0]      STEP_MAX   = STEP_W'(MAX_STEPS);

    t_state                 r_state;
    t_phase                 r_phase;
    logic                   r_pass;
    logic [CHUNK_IDX_W-1:0] r_chunk;
    logic [STEP_W-1:0]      r_steps;
    logic                   r_done;
    t_status                r_status;
    logic                   at_limit;

    assign at_limit = (r_steps >= STEP_MAX);
    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_steps  = r_steps;

    // datapath commands from the current state
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:  o_cmd.load = i_start;
            ST_SETUP: begin
                o_cmd.setup_lin   = !r_pass;
                o_cmd.setup_const = r_pass;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.chunk  = r_chunk;
            end
            ST_DRAIN: ;
            ST_SIGN: begin
                unique case (r_phase)
                    PH_LOWER: begin
                        o_cmd.save_sa    = 1'b1;
                        o_cmd.x_to_upper = 1'b1;
                    end
                    PH_UPPER: begin
                        if (i_stat.same_sign) begin
                            o_cmd.root_wr   = 1'b1;
                            o_cmd.root_zero = 1'b1;
                        end else begin
                            o_cmd.x_to_mid = 1'b1;
                        end
                    end
                    PH_MID:  o_cmd.bisect = 1'b1;
                    default: ;
                endcase
            end
            ST_CHECK: begin
                if (i_stat.span_le_tol || at_limit) begin
                    o_cmd.root_wr = 1'b1;
                end else begin
                    o_cmd.x_to_mid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_LOWER;
            r_pass   <= 1'b0;
            r_chunk  <= '0;
            r_steps  <= '0;
            r_done   <= 1'b0;
            r_status <= STAT_CONVERGED;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_SETUP;
                        r_phase <= PH_LOWER;
                        r_pass  <= 1'b0;
                        r_steps <= '0;
                    end
                end
                ST_SETUP: begin
                    r_chunk <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_chunk == LAST_CHUNK) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                // last partial product lands in the accumulator here
                ST_DRAIN: begin
                    if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_state <= ST_SETUP;
                    end else begin
                        r_state <= ST_SIGN;
                    end
                end
                ST_SIGN: begin
                    unique case (r_phase)
                        PH_LOWER: begin
                            r_phase <= PH_UPPER;
                            r_pass  <= 1'b0;
                            r_state <= ST_SETUP;
                        end
                        PH_UPPER: begin
                            if (i_stat.same_sign) begin
                                r_done   <= 1'b1;
                                r_status <= STAT_NO_SIGN;
                                r_state  <= ST_IDLE;
                            end else begin
                                r_state <= ST_CHECK;
                            end
                        end
                        PH_MID:  r_state <= ST_CHECK;
                        default: r_state <= ST_IDLE;
                    endcase
                end
                // stop test, else start the next halving
                ST_CHECK: begin
                    priority if (i_stat.span_le_tol) begin
                        r_done   <= 1'b1;
                        r_status <= STAT_CONVERGED;
                        r_state  <= ST_IDLE;
                    end else if (at_limit) begin
                        r_done   <= 1'b1;
                        r_status <= STAT_STEP_LIMIT;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_steps <= r_steps + 1'b1;
                        r_phase <= PH_MID;
                        r_pass  <= 1'b0;
                        r_state <= ST_SETUP;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/cubic_root_bisection.sv -----
// top level: bisection root finder for a monic cubic in signed fixed point
// A request (i_start while o_busy is low) gives an interval; one result follows on o_result,
// marked by a one-cycle o_done strobe that cannot be held off, so it must be taken when shown.
// Each polynomial evaluation uses Horner's rule, which needs two multiplies, each done
// as three 32x32 partial products on one shared multiplier plus setup and drain states.
// A request with no sign change finishes once both ends are evaluated; otherwise the result
// comes after N halvings, each with a midpoint evaluation, N being up to MAX_STEPS.
// A new request is taken only while o_busy is low, which includes the cycle of o_done.
module cubic_root_bisection #(
    parameter int unsigned MAX_STEPS = crb_pkg::DEF_MAX_STEPS,
    parameter int unsigned FRAC_BITS = crb_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  crb_pkg::t_cr_req            i_req,
    output logic                        o_done,
    output crb_pkg::t_cr_rsp            o_result,
    input  logic                        i_cfg_we,
    input  crb_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [crb_pkg::DATA_W-1:0]  i_cfg_data
);
    import crb_pkg::*;

    t_dp_cmd                  dp_cmd;
    t_dp_stat                 dp_stat;
    t_status                  ctrl_status;
    logic [STEP_W-1:0]        ctrl_steps;
    logic signed [DATA_W-1:0] dp_root;

    // result fields gathered into one payload
    assign o_result = '{root: dp_root, status: ctrl_status, steps_taken: ctrl_steps};

    // sequencer
    crb_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_status (ctrl_status),
        .o_steps  (ctrl_steps)
    );

    // arithmetic
    crb_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_root     (dp_root)
    );

endmodule

// ----- sv/crb_checker.sv -----
// port-level checker for the cubic root bisection block, bound to the top level
module crb_checker #(
    parameter int unsigned MAX_STEPS = crb_pkg::DEF_MAX_STEPS
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic                 o_done,
    input crb_pkg::t_cr_rsp     o_result
);
    import crb_pkg::*;

    // a taken request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but block not busy");

    // result is shown only once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // busy ends only with a result
    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_done)
        else $error("busy dropped without a result");

    // no sign change gives a zero root and no halvings
    a_no_sign_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STAT_NO_SIGN) |->
            (o_result.root == '0 && o_result.steps_taken == '0))
        else $error("no sign change result not cleared");

    // hitting the step limit means all halvings were used
    a_limit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == STAT_STEP_LIMIT) |->
            (o_result.steps_taken == STEP_W'(MAX_STEPS)))
        else $error("step limit reported with wrong step count");

endmodule

bind cubic_root_bisection crb_checker #(
    .MAX_STEPS (MAX_STEPS)
) u_crb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the cubic root bisection block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import crb_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int NUM_PHASES  = 14;
    localparam logic [DATA_W-1:0] Q_ONE   = 32'h0100_0000;
    localparam logic [DATA_W-1:0] Q_MIN   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_MAX   = 32'h7fff_ffff;
    localparam longint            S32_MAX = 64'sh0000_0000_7fff_ffff;
    localparam longint            S32_MIN = -64'sh0000_0000_8000_0000;

    // expected root store and bisection predictor
    class bisect_scoreboard;
        logic signed [DATA_W-1:0] sq_coef;
        logic signed [DATA_W-1:0] lin_coef;
        logic signed [DATA_W-1:0] const_coef;
        logic [TOL_W-1:0]         stop_width;
        t_cr_rsp                  pending_roots[$];
        int                       errors;

        function new();
            sq_coef    = COEF_SQUARE_RST;
            lin_coef   = COEF_LINEAR_RST;
            const_coef = COEF_CONSTANT_RST;
            stop_width = TOLERANCE_RST;
            errors     = 0;
        endfunction

        function void set_coefs(logic [DATA_W-1:0] sq, logic [DATA_W-1:0] lin,
                                logic [DATA_W-1:0] cst, logic [TOL_W-1:0] tol);
            sq_coef    = sq;
            lin_coef   = lin;
            const_coef = cst;
            stop_width = tol;
        endfunction

        // exact sign of the cubic by horner, scaled by 2^(3*frac)
        function int cubic_sign(logic signed [DATA_W-1:0] x);
            logic signed [127:0] xw;
            logic signed [127:0] c2;
            logic signed [127:0] c1;
            logic signed [127:0] c0;
            logic signed [127:0] acc;
            xw  = x;
            c2  = sq_coef;
            c1  = lin_coef;
            c0  = const_coef;
            acc = (xw + c2) * xw;
            acc = (acc + (c1 <<< DEF_FRAC_BITS)) * xw;
            acc = acc + (c0 <<< (2 * DEF_FRAC_BITS));
            if (acc < 0) return -1;
            if (acc == 0) return 0;
            return 1;
        endfunction

        function t_cr_rsp bisect_interval(t_cr_req r);
            longint      lo;
            longint      hi;
            longint      mid;
            logic [63:0] span_w;
            int          sign_lo;
            int          sign_hi;
            int          halvings;
            t_cr_rsp     res;
            lo      = $signed(r.lower_end);
            hi      = $signed(r.upper_end);
            sign_lo = cubic_sign(lo[DATA_W-1:0]);
            sign_hi = cubic_sign(hi[DATA_W-1:0]);
            res.status = STAT_CONVERGED;
            // same sign at both ends, nothing to bracket
            if (sign_lo * sign_hi > 0) begin
                res.root        = '0;
                res.status      = STAT_NO_SIGN;
                res.steps_taken = '0;
                return res;
            end
            // midpoint floors toward minus infinity
            mid      = (lo + hi) >>> 1;
            halvings = 0;
            span_w   = (lo > hi) ? lo - hi : hi - lo;
            while (span_w > 64'(stop_width)) begin
                if (halvings >= DEF_MAX_STEPS) begin
                    res.status = STAT_STEP_LIMIT;
                    break;
                end
                mid = (lo + hi) >>> 1;
                halvings++;
                // direction follows the sign at the lower end
                if (cubic_sign(mid[DATA_W-1:0]) * sign_lo > 0) lo = mid;
                else hi = mid;
                span_w = (lo > hi) ? lo - hi : hi - lo;
            end
            res.root        = mid[DATA_W-1:0];
            res.steps_taken = STEP_W'(halvings);
            return res;
        endfunction

        function void note_req(t_cr_req r);
            pending_roots.push_back(bisect_interval(r));
        endfunction

        task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            errors++;
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_rsp(t_cr_rsp got);
            t_cr_rsp want;
            if (pending_roots.size() == 0) begin
                report_mismatch("unexpected result root", got.root, '0);
                return;
            end
            want = pending_roots.pop_front();
            if (got.root !== want.root) report_mismatch("root", got.root, want.root);
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
            if (got.steps_taken !== want.steps_taken)
                report_mismatch("steps_taken", got.steps_taken, want.steps_taken);
        endtask

        task report_leftovers();
            if (pending_roots.size() != 0)
                report_mismatch("results never delivered", pending_roots.size(), '0);
        endtask
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_start    = 1'b0;
    t_cr_req            i_req      = '0;
    logic               i_cfg_we   = 1'b0;
    t_cfg_idx           i_cfg_idx  = CFG_COEF_SQUARE;
    logic [DATA_W-1:0]  i_cfg_data = '0;
    logic               o_busy;
    logic               o_done;
    t_cr_rsp            o_result;

    bisect_scoreboard         roots_sb = new();
    logic signed [DATA_W-1:0] root_at[3];
    bit                       roots_known;
    int                       stall_cycles = 0;

    cubic_root_bisection DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // request and result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) roots_sb.note_req(i_req);
            if (o_done) roots_sb.check_rsp(o_result);
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[cubic_root_bisection] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // hold a request until the block takes it
    task automatic drive_req(t_cr_req r);
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            i_start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding request finish
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (roots_sb.pending_roots.size() != 0 || o_busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // write all four registers, block must be idle
    task automatic load_cfg(logic [DATA_W-1:0] sq, logic [DATA_W-1:0] lin,
                            logic [DATA_W-1:0] cst, logic [TOL_W-1:0] tol);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COEF_SQUARE;
        i_cfg_data <= sq;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_COEF_LINEAR;
        i_cfg_data <= lin;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_COEF_CONSTANT;
        i_cfg_data <= cst;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TOLERANCE;
        i_cfg_data <= {1'($urandom_range(0, 1)), tol};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        roots_sb.set_coefs(sq, lin, cst, tol);
    endtask

    // coefficients from three chosen roots within +-4.5
    task automatic load_roots_cfg(logic [TOL_W-1:0] tol);
        longint r1;
        longint r2;
        longint r3;
        longint s1;
        longint p2;
        longint p3;
        r1 = longint'($urandom_range(0, 150994944)) - 75497472;
        r2 = ($urandom_range(0, 3) == 0) ? r1 : longint'($urandom_range(0, 150994944)) - 75497472;
        r3 = longint'($urandom_range(0, 150994944)) - 75497472;
        s1 = r1 + r2 + r3;
        p2 = (r1 * r2 + r1 * r3 + r2 * r3) >>> DEF_FRAC_BITS;
        p3 = (((r1 * r2) >>> DEF_FRAC_BITS) * r3) >>> DEF_FRAC_BITS;
        root_at[0] = r1[DATA_W-1:0];
        root_at[1] = r2[DATA_W-1:0];
        root_at[2] = r3[DATA_W-1:0];
        roots_known = 1'b1;
        load_cfg(32'(-s1), 32'(p2), 32'(-p3), tol);
    endtask

    function automatic t_cr_req req_of(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
        t_cr_req r;
        r.lower_end = lo;
        r.upper_end = hi;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] clamp32(longint v);
        if (v > S32_MAX) return Q_MAX;
        if (v < S32_MIN) return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] extreme_val();
        case ($urandom_range(0, 5))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return '1;
            4: return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [TOL_W-1:0] pick_tol();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return TOL_W'(1);
            3, 4, 5: return TOL_W'($urandom_range(1, 64));
            6, 7: return TOL_W'($urandom_range(1, 1 << 20));
            default: return TOL_W'($urandom());
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int v;
        v = $urandom_range(0, 99);
        if (v < 55) return 0;
        if (v < 85) return $urandom_range(1, 3);
        if (v < 98) return $urandom_range(4, 20);
        return $urandom_range(100, 400);
    endfunction

    // random request: intervals around a root, plus wide, narrow and extreme ones
    function automatic t_cr_req make_req();
        t_cr_req           r;
        longint            ctr;
        longint            w_lo;
        longint            w_hi;
        longint            lo;
        logic [DATA_W-1:0] tmp;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                r.lower_end = $urandom();
                r.upper_end = $urandom();
            end
            3, 4, 5, 6: begin
                if (roots_known) ctr = root_at[$urandom_range(0, 2)];
                else ctr = longint'($urandom_range(0, 32'h1000_0000)) - 64'sh0800_0000;
                w_lo = longint'($urandom() >> $urandom_range(0, 31));
                w_hi = longint'($urandom() >> $urandom_range(0, 31));
                r.lower_end = clamp32(ctr - w_lo);
                r.upper_end = clamp32(ctr + w_hi);
            end
            7: begin
                lo = $signed($urandom());
                r.lower_end = lo[DATA_W-1:0];
                r.upper_end = clamp32(lo + $urandom_range(0, 20));
            end
            8: begin
                r.lower_end = extreme_val();
                r.upper_end = extreme_val();
            end
            default: begin
                r.lower_end = {1'b1, 31'($urandom())};
                r.upper_end = {1'b0, 31'($urandom())};
            end
        endcase
        if ($urandom_range(0, 1)) begin
            tmp         = r.lower_end;
            r.lower_end = r.upper_end;
            r.upper_end = tmp;
        end
        return r;
    endfunction

    // stimulus
    initial begin
        int phase_reqs;
        bit burst;
        root_at = '{32'sd28521267, 32'sd50331648, 32'sd50331648};
        roots_known = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: roots at 1.7 and a double root at 3
        drive_req(req_of(Q_MIN, Q_MAX));
        drive_req(req_of(Q_MAX, Q_MIN));
        drive_req(req_of(Q_MIN, Q_MIN));
        drive_req(req_of(Q_MAX, Q_MAX));
        drive_req(req_of('0, '0));
        drive_req(req_of(32'h0400_0000, 32'h0500_0000));
        drive_req(req_of(Q_ONE, 32'h0200_0000));
        drive_req(req_of(32'h0200_0000, Q_ONE));
        drive_req(req_of(Q_ONE, Q_ONE + 32'd5));
        drive_req(req_of(32'hffff_fffb, '0));
        drive_req(req_of('0, Q_MAX));
        drive_req(req_of(Q_MIN, '0));
        drive_req(req_of(32'h0280_0000, 32'h0380_0000));

        // pure cube: exact zero at an end and at a midpoint
        wait_drained();
        load_cfg('0, '0, '0, TOL_W'(8));
        roots_known = 1'b0;
        drive_req(req_of('0, Q_ONE));
        drive_req(req_of(32'hff00_0000, '0));
        drive_req(req_of(32'hff00_0000, Q_ONE));
        drive_req(req_of(Q_ONE, 32'hff00_0000));

        // zero tolerance: bracketing requests run into the step limit
        wait_drained();
        load_cfg(COEF_SQUARE_RST, COEF_LINEAR_RST, COEF_CONSTANT_RST, '0);
        root_at = '{32'sd28521267, 32'sd50331648, 32'sd50331648};
        roots_known = 1'b1;
        drive_req(req_of(Q_ONE, 32'h0200_0000));
        drive_req(req_of(32'd3, 32'd4));
        drive_req(req_of(32'd5, 32'd5));
        drive_req(req_of(Q_MIN, Q_MAX));

        // random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            roots_known = 1'b0;
            if (ph == 0) begin
                load_cfg(Q_MAX, Q_MAX, Q_MAX, '1);
            end else if (ph == 1) begin
                load_cfg(Q_MIN, Q_MIN, Q_MIN, TOL_W'(1));
            end else if (ph == 2) begin
                load_roots_cfg('0);
            end else if (ph == 3) begin
                load_cfg(COEF_SQUARE_RST, COEF_LINEAR_RST, COEF_CONSTANT_RST, pick_tol());
                root_at = '{32'sd28521267, 32'sd50331648, 32'sd50331648};
                roots_known = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: load_roots_cfg(pick_tol());
                    6, 7, 8: load_cfg($urandom(), $urandom(), $urandom(), pick_tol());
                    default: load_cfg(extreme_val(), extreme_val(), extreme_val(), pick_tol());
                endcase
            end
            phase_reqs = (ph < 2) ? 30 : 95;
            burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_reqs; n++) begin
                drive_req(make_req());
                if ($urandom_range(0, 39) == 0) wait_drained();
                else if (!burst) idle_gap(pick_gap());
            end
        end

        // drain and look for stray results
        wait_drained();
        repeat (60) @(posedge i_clk);
        roots_sb.report_leftovers();
        if (roots_sb.errors == 0) begin
            $display("[cubic_root_bisection] OK");
        end else begin
            $display("[cubic_root_bisection] ERROR");
        end
        $finish;
    end

endmodule
